FILE: hw/rtl/iffp_pkg.sv
// Package for the inertial-sensor FIFO frame parser.
// Holds header codes, frame kinds, the front-to-back command type and helpers.
// No dependencies.
package iffp_pkg;

    localparam int unsigned BURST_BYTES_MAX_DEF = 2048;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned SHADOW_DEPTH = 12;

    localparam logic [7:0] HDR_BOTH   = 8'h8C;
    localparam logic [7:0] HDR_GYRO   = 8'h88;
    localparam logic [7:0] HDR_ACCEL  = 8'h84;
    localparam logic [7:0] HDR_SKIP   = 8'h40;
    localparam logic [7:0] HDR_CONFIG = 8'h48;
    localparam logic [7:0] HDR_DROP   = 8'h50;
    localparam logic [7:0] HDR_TIME   = 8'h44;

    localparam logic [3:0] BOTH_PAYLOAD = 4'd12;
    localparam logic [3:0] ONE_PAYLOAD  = 4'd6;
    localparam logic [3:0] SKIP_SHORT   = 4'd1;
    localparam logic [3:0] SKIP_TIME    = 4'd3;

    localparam logic [15:0] AXIS_MOST_NEG = 16'h8000;
    localparam logic [15:0] AXIS_MOST_POS = 16'h7FFF;

    typedef enum logic [2:0] {
        KIND_HEADER,
        KIND_BOTH,
        KIND_GYRO,
        KIND_ACCEL,
        KIND_SKIP
    } kind_t;

    typedef enum logic [1:0] {
        COMMIT_NONE,
        COMMIT_BOTH,
        COMMIT_GYRO,
        COMMIT_ACCEL
    } commit_t;

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] pos;
        logic       wr;
        commit_t    commit;
        logic       last;
    } cmd_t;

    function automatic logic [15:0] neg_sat(input logic [15:0] v);
        logic [15:0] r;
        if (v == AXIS_MOST_NEG) begin
            r = AXIS_MOST_POS;
        end else begin
            r = 16'(16'd0 - v);
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/iffp_front.sv
// Front end of the frame parser: accepts bytes, tracks frame headers and the
// burst byte limit, and turns each byte into a command for the back end.
// Depends on iffp_pkg.
module iffp_front #(
    parameter int unsigned BURST_BYTES_MAX = iffp_pkg::BURST_BYTES_MAX_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_fifo_byte,
    input  logic           s_burst_last,
    input  logic           q_full,
    output logic           q_push,
    output iffp_pkg::cmd_t q_cmd
);
    import iffp_pkg::*;

    localparam int unsigned CW = $clog2(BURST_BYTES_MAX + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(BURST_BYTES_MAX);

    kind_t         kind_reg, kind_next;
    logic [3:0]    left_reg, left_next;
    logic [CW-1:0] count_reg, count_next;
    logic          in_range;
    logic [3:0]    total;

    assign s_ready  = !q_full;
    assign q_push   = s_valid && s_ready;
    assign in_range = count_reg < COUNT_MAX;
    assign total    = (kind_reg == KIND_BOTH) ? BOTH_PAYLOAD : ONE_PAYLOAD;

    always_comb begin
        kind_next  = kind_reg;
        left_next  = left_reg;
        count_next = count_reg;
        if (q_push) begin
            if (in_range) begin
                count_next = count_reg + 1'b1;
                if (kind_reg == KIND_HEADER) begin
                    case (s_fifo_byte)
                        HDR_BOTH: begin
                            kind_next = KIND_BOTH;
                            left_next = BOTH_PAYLOAD;
                        end
                        HDR_GYRO: begin
                            kind_next = KIND_GYRO;
                            left_next = ONE_PAYLOAD;
                        end
                        HDR_ACCEL: begin
                            kind_next = KIND_ACCEL;
                            left_next = ONE_PAYLOAD;
                        end
                        HDR_SKIP, HDR_CONFIG, HDR_DROP: begin
                            kind_next = KIND_SKIP;
                            left_next = SKIP_SHORT;
                        end
                        HDR_TIME: begin
                            kind_next = KIND_SKIP;
                            left_next = SKIP_TIME;
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    left_next = left_reg - 1'b1;
                    if (left_reg == 4'd1) begin
                        kind_next = KIND_HEADER;
                    end
                end
            end
            if (s_burst_last) begin
                kind_next  = KIND_HEADER;
                left_next  = '0;
                count_next = '0;
            end
        end
    end

    always_comb begin
        q_cmd.data   = s_fifo_byte;
        q_cmd.last   = s_burst_last;
        q_cmd.pos    = total - left_reg;
        q_cmd.wr     = in_range && (kind_reg == KIND_BOTH || kind_reg == KIND_GYRO
                                    || kind_reg == KIND_ACCEL);
        q_cmd.commit = COMMIT_NONE;
        if (in_range && left_reg == 4'd1) begin
            case (kind_reg)
                KIND_BOTH:  q_cmd.commit = COMMIT_BOTH;
                KIND_GYRO:  q_cmd.commit = COMMIT_GYRO;
                KIND_ACCEL: q_cmd.commit = COMMIT_ACCEL;
                default:    q_cmd.commit = COMMIT_NONE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg  <= KIND_HEADER;
            left_reg  <= '0;
            count_reg <= '0;
        end else begin
            kind_reg  <= kind_next;
            left_reg  <= left_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: hw/rtl/iffp_queue.sv
// Short command queue between the front and back ends of the frame parser.
// Depends on iffp_pkg.
module iffp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  iffp_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output iffp_pkg::cmd_t pop_cmd
);
    import iffp_pkg::*;

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg, count_next;

    assign full    = count_reg == CNT_W'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: hw/rtl/iffp_back.sv
// Back end of the frame parser: stores payload bytes, assembles axis values on
// frame completion and registers one result at the end of each burst that
// completed a sample frame. Depends on iffp_pkg.
module iffp_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  iffp_pkg::cmd_t     q_cmd,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_accel_x,
    output logic signed [15:0] m_accel_y,
    output logic signed [15:0] m_accel_z,
    output logic signed [15:0] m_gyro_x,
    output logic signed [15:0] m_gyro_y,
    output logic signed [15:0] m_gyro_z
);
    import iffp_pkg::*;

    logic [7:0]  shadow_reg [SHADOW_DEPTH];
    logic [7:0]  view       [SHADOW_DEPTH];
    logic [15:0] accel_reg  [3];
    logic [15:0] gyro_reg   [3];
    logic [15:0] accel_next [3];
    logic [15:0] gyro_next  [3];
    logic        sample_reg, sample_next;
    logic        m_valid_reg, m_valid_next;
    logic        emit;

    assign q_pop   = q_valid && (!m_valid_reg || m_ready);
    assign emit    = q_pop && q_cmd.last && sample_next;
    assign m_valid = m_valid_reg;

    always_comb begin
        for (int i = 0; i < SHADOW_DEPTH; i++) begin
            view[i] = (q_cmd.wr && q_cmd.pos == 4'(i)) ? q_cmd.data : shadow_reg[i];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            accel_next[i] = accel_reg[i];
            gyro_next[i]  = gyro_reg[i];
        end
        sample_next = sample_reg;
        case (q_cmd.commit)
            COMMIT_BOTH: begin
                for (int i = 0; i < 3; i++) begin
                    gyro_next[i]  = {view[2*i+1], view[2*i]};
                    accel_next[i] = {view[2*i+7], view[2*i+6]};
                end
                sample_next = 1'b1;
            end
            COMMIT_GYRO: begin
                for (int i = 0; i < 3; i++) begin
                    gyro_next[i] = {view[2*i+1], view[2*i]};
                end
                sample_next = 1'b1;
            end
            COMMIT_ACCEL: begin
                for (int i = 0; i < 3; i++) begin
                    accel_next[i] = {view[2*i+1], view[2*i]};
                end
                sample_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_cmd.wr) begin
            shadow_reg[q_cmd.pos] <= q_cmd.data;
        end
        if (emit) begin
            m_accel_x <= accel_next[0];
            m_accel_y <= neg_sat(accel_next[1]);
            m_accel_z <= neg_sat(accel_next[2]);
            m_gyro_x  <= gyro_next[0];
            m_gyro_y  <= neg_sat(gyro_next[1]);
            m_gyro_z  <= neg_sat(gyro_next[2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                accel_reg[i] <= '0;
                gyro_reg[i]  <= '0;
            end
            sample_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                for (int i = 0; i < 3; i++) begin
                    accel_reg[i] <= q_cmd.last ? '0 : accel_next[i];
                    gyro_reg[i]  <= q_cmd.last ? '0 : gyro_next[i];
                end
                sample_reg <= q_cmd.last ? 1'b0 : sample_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: hw/rtl/imu_fifo_frame_parser.sv
// Top level of the inertial-sensor FIFO frame parser.
// Depends on iffp_pkg, iffp_front, iffp_queue and iffp_back.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_fifo_byte, s_burst_last
//   m_        out        m_valid/m_ready    m_accel_x/y/z, m_gyro_x/y/z
//
// One byte is accepted per cycle when the result side does not stall.
// m_valid is registered and rises once the back end pops the last byte of a burst that held a sample.
// A two-entry queue decouples byte parsing from the result register.
// Reset is synchronous on aresetn; no clearing pass is needed after it.
// While a result waits on m_ready the back end stops, the queue fills and s_ready drops.
module imu_fifo_frame_parser #(
    parameter int unsigned BURST_BYTES_MAX = iffp_pkg::BURST_BYTES_MAX_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_fifo_byte,
    input  logic               s_burst_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_accel_x,
    output logic signed [15:0] m_accel_y,
    output logic signed [15:0] m_accel_z,
    output logic signed [15:0] m_gyro_x,
    output logic signed [15:0] m_gyro_y,
    output logic signed [15:0] m_gyro_z
);
    import iffp_pkg::*;

    cmd_t push_cmd, pop_cmd;
    logic push, full, pop, q_valid;

    iffp_front #(
        .BURST_BYTES_MAX(BURST_BYTES_MAX)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_fifo_byte (s_fifo_byte),
        .s_burst_last(s_burst_last),
        .q_full      (full),
        .q_push      (push),
        .q_cmd       (push_cmd)
    );

    iffp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_cmd(push_cmd),
        .full    (full),
        .pop     (pop),
        .q_valid (q_valid),
        .pop_cmd (pop_cmd)
    );

    iffp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (pop_cmd),
        .q_pop    (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_accel_x(m_accel_x),
        .m_accel_y(m_accel_y),
        .m_accel_z(m_accel_z),
        .m_gyro_x (m_gyro_x),
        .m_gyro_y (m_gyro_y),
        .m_gyro_z (m_gyro_z)
    );

endmodule

FILE: hw/rtl/iffp_checker.sv
// Port-level checks for the frame parser, bound to its top level.
// Depends on imu_fifo_frame_parser.
module iffp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_accel_x,
    input logic signed [15:0] m_accel_y,
    input logic signed [15:0] m_accel_z,
    input logic signed [15:0] m_gyro_x,
    input logic signed [15:0] m_gyro_y,
    input logic signed [15:0] m_gyro_z
);

    // A stalled result keeps its values; accel_x, accel_y, gyro_x and gyro_z are checked.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_accel_x) && $stable(m_accel_y)
            && $stable(m_gyro_x) && $stable(m_gyro_z))
        else $error("stalled result changed");

    // Negated axes saturate, so they never show the most negative value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_accel_y != 16'sh8000 && m_accel_z != 16'sh8000
            && m_gyro_y != 16'sh8000 && m_gyro_z != 16'sh8000)
        else $error("negated axis not saturated");

    // After reset the block is empty and ready for a request.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

    // A result side that took every cycle leaves room in the queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |=> s_ready)
        else $error("input stalled although result side was ready");

endmodule

bind imu_fifo_frame_parser iffp_checker u_iffp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_accel_x(m_accel_x),
    .m_accel_y(m_accel_y),
    .m_accel_z(m_accel_z),
    .m_gyro_x (m_gyro_x),
    .m_gyro_y (m_gyro_y),
    .m_gyro_z (m_gyro_z)
);

FILE: bench/testbench.sv
// Self-checking testbench for imu_fifo_frame_parser: directed and random FIFO bursts
// are checked against an in-bench frame decoder. Depends on iffp_pkg and the parser RTL.
`timescale 1ns / 100ps

module testbench;
    import iffp_pkg::*;

    localparam int unsigned BURST_LIMIT = BURST_BYTES_MAX_DEF;
    localparam int RANDOM_BYTES = 700;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_req_t;

    // Index 0 is accel_x, then accel_y, accel_z, gyro_x, gyro_y, gyro_z.
    typedef logic [5:0][15:0] sample_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_fifo_byte = 8'h00;
    logic               s_burst_last = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_accel_x;
    logic signed [15:0] m_accel_y;
    logic signed [15:0] m_accel_z;
    logic signed [15:0] m_gyro_x;
    logic signed [15:0] m_gyro_y;
    logic signed [15:0] m_gyro_z;

    imu_fifo_frame_parser u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_fifo_byte  (s_fifo_byte),
        .s_burst_last (s_burst_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_accel_x    (m_accel_x),
        .m_accel_y    (m_accel_y),
        .m_accel_z    (m_accel_z),
        .m_gyro_x     (m_gyro_x),
        .m_gyro_y     (m_gyro_y),
        .m_gyro_z     (m_gyro_z)
    );

    byte_req_t  fifo_bytes_q[$];
    sample_t    samples_due_q[$];
    logic [7:0] burst_body[$];
    byte_req_t  head_req;
    sample_t    got_sample;
    sample_t    want_sample;
    string      axis_name[6] = '{"accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y", "gyro_z"};

    int  errors = 0;
    int  cycle_count = 0;
    logic s_taken = 1'b0;
    logic calm = 1'b0;
    int  gap_left = 0;
    int  tx_stretch = 0;
    logic tx_busy = 1'b1;
    int  stall_left = 0;
    int  rx_stretch = 0;
    logic rx_busy = 1'b1;

    kind_t       frame_kind;
    logic [3:0]  bytes_left;
    logic [7:0]  shadow [12];
    logic [15:0] accel_hold [3];
    logic [15:0] gyro_hold [3];
    logic        have_sample;
    int unsigned burst_count;

    function automatic logic [15:0] negate_clamped(input logic [15:0] v);
        return (v == 16'h8000) ? 16'h7FFF : ~v + 16'd1;
    endfunction

    function automatic logic [15:0] word_at(input int pos);
        return {shadow[pos + 1], shadow[pos]};
    endfunction

    task automatic clear_burst();
        frame_kind = KIND_HEADER;
        bytes_left = 4'd0;
        have_sample = 1'b0;
        burst_count = 0;
        for (int k = 0; k < 3; k++) begin
            accel_hold[k] = 16'd0;
            gyro_hold[k] = 16'd0;
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        int      total;
        sample_t due;
        if (burst_count < BURST_LIMIT) begin
            burst_count++;
            if (frame_kind == KIND_HEADER) begin
                case (b)
                    HDR_BOTH: begin
                        frame_kind = KIND_BOTH;
                        bytes_left = BOTH_PAYLOAD;
                    end
                    HDR_GYRO: begin
                        frame_kind = KIND_GYRO;
                        bytes_left = ONE_PAYLOAD;
                    end
                    HDR_ACCEL: begin
                        frame_kind = KIND_ACCEL;
                        bytes_left = ONE_PAYLOAD;
                    end
                    HDR_SKIP, HDR_CONFIG, HDR_DROP: begin
                        frame_kind = KIND_SKIP;
                        bytes_left = SKIP_SHORT;
                    end
                    HDR_TIME: begin
                        frame_kind = KIND_SKIP;
                        bytes_left = SKIP_TIME;
                    end
                    default: begin
                    end
                endcase
            end else begin
                total = (frame_kind == KIND_BOTH) ? int'(BOTH_PAYLOAD) : int'(ONE_PAYLOAD);
                if (frame_kind != KIND_SKIP) begin
                    shadow[total - int'(bytes_left)] = b;
                end
                bytes_left = bytes_left - 4'd1;
                if (bytes_left == 4'd0) begin
                    for (int k = 0; k < 3; k++) begin
                        case (frame_kind)
                            KIND_BOTH: begin
                                gyro_hold[k] = word_at(2 * k);
                                accel_hold[k] = word_at(6 + 2 * k);
                            end
                            KIND_GYRO: gyro_hold[k] = word_at(2 * k);
                            KIND_ACCEL: accel_hold[k] = word_at(2 * k);
                            default: begin
                            end
                        endcase
                    end
                    if (frame_kind != KIND_SKIP) begin
                        have_sample = 1'b1;
                    end
                    frame_kind = KIND_HEADER;
                end
            end
        end
        if (last) begin
            if (have_sample) begin
                due[0] = accel_hold[0];
                due[1] = negate_clamped(accel_hold[1]);
                due[2] = negate_clamped(accel_hold[2]);
                due[3] = gyro_hold[0];
                due[4] = negate_clamped(gyro_hold[1]);
                due[5] = negate_clamped(gyro_hold[2]);
                samples_due_q.push_back(due);
            end
            clear_burst();
        end
    endtask

    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic build_frames(input int count);
        logic [7:0] hdr;
        int         plen;
        for (int f = 0; f < count; f++) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 4, 5: begin
                    hdr = HDR_BOTH;
                    plen = 12;
                end
                6, 7: begin
                    hdr = HDR_GYRO;
                    plen = 6;
                end
                8, 9: begin
                    hdr = HDR_ACCEL;
                    plen = 6;
                end
                10: begin
                    hdr = HDR_SKIP;
                    plen = 1;
                end
                11: begin
                    hdr = HDR_CONFIG;
                    plen = 1;
                end
                12: begin
                    hdr = HDR_DROP;
                    plen = 1;
                end
                13: begin
                    hdr = HDR_TIME;
                    plen = 3;
                end
                default: begin
                    hdr = 8'($urandom);
                    plen = 0;
                end
            endcase
            burst_body.push_back(hdr);
            repeat (plen) burst_body.push_back(pick_data());
        end
    endtask

    task automatic queue_burst(input int cut);
        byte_req_t r;
        for (int i = 0; i < cut; i++) begin
            r.data = burst_body[i];
            r.last = (i == cut - 1);
            fifo_bytes_q.push_back(r);
        end
        burst_body.delete();
    endtask

    task automatic queue_random_bursts(input int byte_goal);
        int sent;
        int cut;
        sent = 0;
        while (sent < byte_goal) begin
            build_frames($urandom_range(1, 6));
            if ($urandom_range(0, 4) == 0) begin
                cut = $urandom_range(1, burst_body.size());
            end else begin
                cut = burst_body.size();
            end
            sent += cut;
            queue_burst(cut);
        end
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        clear_burst();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        burst_body = '{HDR_BOTH, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'hFF,
                       8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00};
        queue_burst(burst_body.size());
        burst_body = '{HDR_SKIP, 8'h8C, HDR_CONFIG, 8'h88, HDR_DROP, 8'h84,
                       HDR_TIME, 8'h8C, 8'h40, 8'h44, 8'h00};
        queue_burst(burst_body.size());
        burst_body = '{HDR_GYRO, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06,
                       HDR_ACCEL, 8'hAA, 8'h55};
        queue_burst(burst_body.size());

        // The sender holds off here until every result of the directed requests is back.
        while (fifo_bytes_q.size() != 0 || s_valid || samples_due_q.size() != 0) begin
            @(posedge aclk);
        end

        queue_random_bursts(RANDOM_BYTES / 2);
        queue_random_bursts(RANDOM_BYTES / 2);

        while (fifo_bytes_q.size() > 80) begin
            @(negedge aclk);
        end
        calm = 1'b1;
        while (fifo_bytes_q.size() != 0 || s_valid || samples_due_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (fifo_bytes_q.size() == 0) begin
                s_valid <= 1'b0;
            end else begin
                head_req = fifo_bytes_q.pop_front();
                s_valid <= 1'b1;
                s_fifo_byte <= head_req.data;
                s_burst_last <= head_req.last;
                if (tx_stretch == 0) begin
                    tx_busy = ($urandom_range(0, 2) != 0);
                    tx_stretch = $urandom_range(20, 150);
                end else begin
                    tx_stretch--;
                end
                if (!calm && tx_busy && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(1, 11);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (rx_stretch == 0) begin
                rx_busy = ($urandom_range(0, 2) != 0);
                rx_stretch = $urandom_range(20, 200);
            end else begin
                rx_stretch--;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && rx_busy && $urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, 11);
                end
            end
        end
    end

    always @(posedge aclk) begin
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                parse_byte(s_fifo_byte, s_burst_last);
            end
            if (m_valid && m_ready) begin
                got_sample = {m_gyro_z, m_gyro_y, m_gyro_x, m_accel_z, m_accel_y, m_accel_x};
                if (samples_due_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, %s %0d %0d %0d %0d %0d %0d",
                             $time, "actual", m_accel_x, m_accel_y, m_accel_z,
                             m_gyro_x, m_gyro_y, m_gyro_z);
                    errors++;
                end else begin
                    want_sample = samples_due_q.pop_front();
                    for (int k = 0; k < 6; k++) begin
                        if (got_sample[k] !== want_sample[k]) begin
                            $display("%0t: %s expected %0d actual %0d", $time, axis_name[k],
                                     $signed(want_sample[k]), $signed(got_sample[k]));
                            errors++;
                        end
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
